// ===== rtl/sdfcsg_pkg.sv =====
// sdfcsg_pkg: shared constants and types for the SDF CSG combine core.
// Used by sdfcsg_div and sdf_csg_combine_core; depends on nothing.
package sdfcsg_pkg;

    // Operation selector codes
    localparam logic [2:0] ACT_UNION             = 3'd0;
    localparam logic [2:0] ACT_SUBTRACT          = 3'd1;
    localparam logic [2:0] ACT_INTERSECT         = 3'd2;
    localparam logic [2:0] ACT_SMOOTH_UNION      = 3'd3;
    localparam logic [2:0] ACT_SMOOTH_SUBTRACT   = 3'd4;
    localparam logic [2:0] ACT_SMOOTH_INTERSECT  = 3'd5;

    // Blend weight is Q1.16
    localparam logic [16:0] H_ONE  = 17'd65536;
    localparam logic [16:0] H_HALF = 17'd32768;

    // Weight quotient bits, one per divider stage
    localparam int DIV_STEPS = 15;

    // Fixed pipeline depth from accepted start to result strobe
    localparam int LATENCY = DIV_STEPS + 6;

    // Payload that rides along the divider
    typedef struct packed {
        logic               smooth;
        logic               minus_c;
        logic               sat_hi;
        logic               sat_lo;
        logic               neg;
        logic signed [31:0] a;
        logic signed [32:0] y;
        logic [30:0]        k;
        logic [15:0]        ac_red;
        logic [15:0]        ac_green;
        logic [15:0]        ac_blue;
        logic [15:0]        bc_red;
        logic [15:0]        bc_green;
        logic [15:0]        bc_blue;
        logic [31:0]        hard_dist;
        logic [15:0]        hard_red;
        logic [15:0]        hard_green;
        logic [15:0]        hard_blue;
    } t_tag;

    // Divider result bundle
    typedef struct packed {
        logic                   valid;
        logic [DIV_STEPS-1:0]   quo;
        logic                   rem_nz;
        t_tag                   tag;
    } t_div_out;

endpackage

// ===== rtl/sdfcsg_div.sv =====
// sdfcsg_div: pipelined restoring divider, one quotient bit per stage.
// Computes floor(rem * 2^DIV_STEPS / k) for rem < k; depends on sdfcsg_pkg.
module sdfcsg_div
    import sdfcsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [30:0] i_rem,
    input  t_tag        i_tag,
    output t_div_out    o_res
);

    logic                 r_valid [DIV_STEPS];
    logic [30:0]          r_rem   [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo   [DIV_STEPS];
    t_tag                 r_tag   [DIV_STEPS];

    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++) begin : g_step
            logic                 src_valid;
            logic [30:0]          src_rem;
            logic [DIV_STEPS-1:0] src_quo;
            t_tag                 src_tag;
            logic [31:0]          dbl;
            logic [31:0]          diff;
            logic                 bit_q;
            logic [30:0]          n_rem;

            if (j == 0) begin : g_first
                assign src_valid = i_valid;
                assign src_rem   = i_rem;
                assign src_quo   = '0;
                assign src_tag   = i_tag;
            end else begin : g_next
                assign src_valid = r_valid[j-1];
                assign src_rem   = r_rem[j-1];
                assign src_quo   = r_quo[j-1];
                assign src_tag   = r_tag[j-1];
            end

            // Shift partial remainder and try subtracting k
            assign dbl   = {src_rem, 1'b0};
            assign diff  = dbl - {1'b0, src_tag.k};
            assign bit_q = (dbl >= {1'b0, src_tag.k});
            assign n_rem = bit_q ? diff[30:0] : dbl[30:0];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else begin
                    r_valid[j] <= src_valid;
                end
                r_rem[j] <= n_rem;
                r_quo[j] <= {src_quo[DIV_STEPS-2:0], bit_q};
                r_tag[j] <= src_tag;
            end
        end
    endgenerate

    assign o_res.valid  = r_valid[DIV_STEPS-1];
    assign o_res.quo    = r_quo[DIV_STEPS-1];
    assign o_res.rem_nz = (r_rem[DIV_STEPS-1] != '0);
    assign o_res.tag    = r_tag[DIV_STEPS-1];

`ifndef SYNTH
    // Remainder stays below the divisor at the last step
    a_rem_lt_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[DIV_STEPS-1] |-> (r_rem[DIV_STEPS-1] < r_tag[DIV_STEPS-1].k))
        else $error("divider remainder not below k");
    // Valid moves through the whole pipeline
    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##(DIV_STEPS) r_valid[DIV_STEPS-1])
        else $error("divider lost a transaction");
    // No result without an entry
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[DIV_STEPS-1] |-> $past(i_valid, DIV_STEPS))
        else $error("divider produced a spurious transaction");
`endif

endmodule

// ===== rtl/sdf_csg_combine_core.sv =====
// sdf_csg_combine_core: hard and smooth CSG combine of two colored SDF samples.
// Path to o_valid: stages 0 and 1, the divider, then stages H, M, C and F.
// Throughput: one transaction per cycle; busy is always low.
// The 15-stage weight divider sets the depth; multipliers take two stages.
// Reset (i_rst_n low, synchronous) clears all pipeline valid bits only.
// Output is a one-cycle strobe; the receiver cannot stall.
module sdf_csg_combine_core
    import sdfcsg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_a_dist,
    input  logic [15:0]        i_a_red,
    input  logic [15:0]        i_a_green,
    input  logic [15:0]        i_a_blue,
    input  logic signed [31:0] i_b_dist,
    input  logic [15:0]        i_b_red,
    input  logic [15:0]        i_b_green,
    input  logic [15:0]        i_b_blue,
    input  logic [30:0]        i_smooth_width,
    output logic               o_valid,
    output logic signed [31:0] o_out_dist,
    output logic [15:0]        o_out_red,
    output logic [15:0]        o_out_green,
    output logic [15:0]        o_out_blue
);

    assign busy = 1'b0;

    // ---------------- stage 0: capture inputs ----------------
    logic               r0_valid;
    logic [2:0]         r0_action;
    logic signed [31:0] r0_a;
    logic signed [31:0] r0_b;
    logic [15:0]        r0_ar, r0_ag, r0_ab, r0_br, r0_bg, r0_bb;
    logic [30:0]        r0_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start & ~busy;
        end
        r0_action <= i_action;
        r0_a      <= i_a_dist;
        r0_b      <= i_b_dist;
        r0_ar     <= i_a_red;
        r0_ag     <= i_a_green;
        r0_ab     <= i_a_blue;
        r0_br     <= i_b_red;
        r0_bg     <= i_b_green;
        r0_bb     <= i_b_blue;
        r0_k      <= i_smooth_width;
    end

    // ---------------- stage 1: difference, flags, hard result ----------------
    logic signed [33:0] a34, b34, s34, sum_ab, abs_s;
    logic signed [32:0] nb33, y33, d33;
    logic [30:0]        k_eff;
    logic               neg, ge_k, take_a;
    logic [31:0]        hard_d;
    t_tag               n1_tag;
    logic [30:0]        n1_rem;

    always_comb begin
        a34    = {{2{r0_a[31]}}, r0_a};
        b34    = {{2{r0_b[31]}}, r0_b};
        sum_ab = a34 + b34;
        nb33   = -{r0_b[31], r0_b};
        k_eff  = (r0_k == '0) ? 31'd1 : r0_k;

        // Select signed difference that drives the weight
        case (r0_action) inside
            ACT_SUBTRACT, ACT_SMOOTH_SUBTRACT:   s34 = -sum_ab;
            ACT_INTERSECT, ACT_SMOOTH_INTERSECT: s34 = b34 - a34;
            default:                             s34 = a34 - b34;
        endcase
        y33 = (r0_action == ACT_SUBTRACT || r0_action == ACT_SMOOTH_SUBTRACT)
            ? nb33 : {r0_b[31], r0_b};

        neg   = s34[33];
        abs_s = neg ? -s34 : s34;
        ge_k  = (abs_s >= $signed({3'b000, k_eff}));

        // Hard mode pick
        case (r0_action)
            ACT_SUBTRACT:  take_a = (sum_ab > 34'sd0);
            ACT_INTERSECT: take_a = (r0_a > r0_b);
            default:       take_a = (r0_a < r0_b);
        endcase
        d33 = take_a ? {r0_a[31], r0_a}
            : ((r0_action == ACT_SUBTRACT) ? nb33 : {r0_b[31], r0_b});
        if (d33[32] != d33[31]) begin
            hard_d = d33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            hard_d = d33[31:0];
        end

        n1_tag.smooth     = (r0_action == ACT_SMOOTH_UNION)
                         || (r0_action == ACT_SMOOTH_SUBTRACT)
                         || (r0_action == ACT_SMOOTH_INTERSECT);
        n1_tag.minus_c    = (r0_action == ACT_SMOOTH_UNION);
        n1_tag.sat_hi     = ge_k & ~neg;
        n1_tag.sat_lo     = ge_k & neg;
        n1_tag.neg        = neg;
        n1_tag.a          = r0_a;
        n1_tag.y          = y33;
        n1_tag.k          = k_eff;
        n1_tag.ac_red     = r0_ar;
        n1_tag.ac_green   = r0_ag;
        n1_tag.ac_blue    = r0_ab;
        n1_tag.bc_red     = r0_br;
        n1_tag.bc_green   = r0_bg;
        n1_tag.bc_blue    = r0_bb;
        n1_tag.hard_dist  = hard_d;
        n1_tag.hard_red   = take_a ? r0_ar : r0_br;
        n1_tag.hard_green = take_a ? r0_ag : r0_bg;
        n1_tag.hard_blue  = take_a ? r0_ab : r0_bb;

        // Start the divider at zero when the weight is already clamped
        n1_rem = ge_k ? '0 : abs_s[30:0];
    end

    logic        r1_valid;
    t_tag        r1_tag;
    logic [30:0] r1_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
        r1_tag <= n1_tag;
        r1_rem <= n1_rem;
    end

    // ---------------- divider: |s| * 2^15 / k ----------------
    t_div_out div_res;

    sdfcsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_valid),
        .i_rem   (r1_rem),
        .i_tag   (r1_tag),
        .o_res   (div_res)
    );

    // ---------------- stage H: blend weight ----------------
    logic [16:0] n_h;
    logic [16:0] q_adj;

    always_comb begin
        q_adj = {2'b00, div_res.quo} + {16'd0, div_res.rem_nz};
        if (div_res.tag.sat_hi) begin
            n_h = H_ONE;
        end else if (div_res.tag.sat_lo) begin
            n_h = '0;
        end else if (div_res.tag.neg) begin
            n_h = H_HALF - q_adj;
        end else begin
            n_h = H_HALF + {2'b00, div_res.quo};
        end
    end

    logic        rh_valid;
    logic [16:0] rh_h;
    t_tag        rh_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rh_valid <= 1'b0;
        end else begin
            rh_valid <= div_res.valid;
        end
        rh_h   <= n_h;
        rh_tag <= div_res.tag;
    end

    // ---------------- stage M: products ----------------
    logic [16:0]        g;
    logic signed [49:0] n_pa;
    logic signed [50:0] n_py;
    logic [33:0]        n_p;
    logic [32:0]        n_car, n_cag, n_cab, n_cbr, n_cbg, n_cbb;

    always_comb begin
        g     = H_ONE - rh_h;
        n_pa  = 50'(rh_tag.a) * 50'($signed({1'b0, g}));
        n_py  = 51'(rh_tag.y) * 51'($signed({1'b0, rh_h}));
        n_p   = {17'd0, rh_h} * {17'd0, g};
        n_car = {17'd0, rh_tag.ac_red}   * {16'd0, g};
        n_cag = {17'd0, rh_tag.ac_green} * {16'd0, g};
        n_cab = {17'd0, rh_tag.ac_blue}  * {16'd0, g};
        n_cbr = {17'd0, rh_tag.bc_red}   * {16'd0, rh_h};
        n_cbg = {17'd0, rh_tag.bc_green} * {16'd0, rh_h};
        n_cbb = {17'd0, rh_tag.bc_blue}  * {16'd0, rh_h};
    end

    logic               rm_valid;
    t_tag               rm_tag;
    logic signed [49:0] rm_pa;
    logic signed [50:0] rm_py;
    logic [32:0]        rm_p;
    logic [32:0]        rm_car, rm_cag, rm_cab, rm_cbr, rm_cbg, rm_cbb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_valid <= 1'b0;
        end else begin
            rm_valid <= rh_valid;
        end
        rm_tag <= rh_tag;
        rm_pa  <= n_pa;
        rm_py  <= n_py;
        rm_p   <= n_p[32:0];
        rm_car <= n_car;
        rm_cag <= n_cag;
        rm_cab <= n_cab;
        rm_cbr <= n_cbr;
        rm_cbg <= n_cbg;
        rm_cbb <= n_cbb;
    end

    // ---------------- stage C: correction partials, blend sums ----------------
    logic signed [51:0] n_m;
    logic [47:0]        n_kh;
    logic [46:0]        n_kl;
    logic [32:0]        t_r, t_g, t_b;

    always_comb begin
        n_m  = 52'(rm_pa) + 52'(rm_py);
        n_kh = {17'd0, rm_tag.k} * {31'd0, rm_p[32:16]};
        n_kl = {16'd0, rm_tag.k} * {31'd0, rm_p[15:0]};
        t_r  = rm_car + rm_cbr + 33'(H_HALF);
        t_g  = rm_cag + rm_cbg + 33'(H_HALF);
        t_b  = rm_cab + rm_cbb + 33'(H_HALF);
    end

    logic               rc_valid;
    t_tag               rc_tag;
    logic signed [51:0] rc_m;
    logic [47:0]        rc_kh;
    logic [46:0]        rc_kl;
    logic [15:0]        rc_r, rc_g, rc_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_valid <= 1'b0;
        end else begin
            rc_valid <= rm_valid;
        end
        rc_tag <= rm_tag;
        rc_m   <= n_m;
        rc_kh  <= n_kh;
        rc_kl  <= n_kl;
        rc_r   <= t_r[31:16];
        rc_g   <= t_g[31:16];
        rc_b   <= t_b[31:16];
    end

    // ---------------- stage F: apply correction, round, saturate ----------------
    logic [63:0]        kp;
    logic [63:0]        kp_rnd;
    logic signed [63:0] c64, tot;
    logic signed [47:0] dq;
    logic [31:0]        sm_dist;

    always_comb begin
        kp     = {rc_kh, 16'd0} + {17'd0, rc_kl};
        kp_rnd = kp + 64'(H_HALF);
        c64    = $signed({16'd0, kp_rnd[63:16]});
        tot    = rc_tag.minus_c ? (64'(rc_m) - c64) : (64'(rc_m) + c64);
        tot    = tot + 64'sd32768;
        dq     = tot[63:16];
        if (dq > 48'sh0000_7FFF_FFFF) begin
            sm_dist = 32'h7FFF_FFFF;
        end else if (dq < -48'sh0000_8000_0000) begin
            sm_dist = 32'h8000_0000;
        end else begin
            sm_dist = dq[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= rc_valid;
        end
        o_out_dist  <= rc_tag.smooth ? sm_dist : rc_tag.hard_dist;
        o_out_red   <= rc_tag.smooth ? rc_r : rc_tag.hard_red;
        o_out_green <= rc_tag.smooth ? rc_g : rc_tag.hard_green;
        o_out_blue  <= rc_tag.smooth ? rc_b : rc_tag.hard_blue;
    end

`ifndef SYNTH
    // Every accepted transaction yields a strobe after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(LATENCY) o_valid)
        else $error("transaction lost in pipeline");
    // No strobe without a matching accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("spurious result strobe");
    // Blend weight stays within [0, 1]
    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rh_valid |-> (rh_h <= H_ONE))
        else $error("blend weight out of range");
    // A clamped weight is never both ends
    a_sat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid |-> !(r1_tag.sat_hi && r1_tag.sat_lo))
        else $error("weight clamped both ways");
`endif

endmodule
